/* src/assert_macros.svh */
// Assertion macros for the cheat code decoder RTL.
// No dependencies; assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CCSD_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define CCSD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CCSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CCSD_ASSERT(lbl, clk, rst_n, expr)
`define CCSD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define CCSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* src/ccsd_pkg.sv */
// Package for the cheat code string decoder: constants, types, character classifier.
// No dependencies.
`default_nettype none

package ccsd_pkg;

    localparam int BufDepth   = 11;
    localparam int CountMax   = 12;
    localparam int CntW       = 4;
    localparam int QueueDepth = 2;

    localparam logic [2:0] CT_NONE = 3'd0;
    localparam logic [2:0] CT_GG8  = 3'd1;
    localparam logic [2:0] CT_AR8  = 3'd2;
    localparam logic [2:0] CT_GG16 = 3'd3;
    localparam logic [2:0] CT_AR16 = 3'd4;

    localparam logic [3:0] NibbleMask = 4'hF;
    localparam logic [7:0] CmpKey     = 8'hBA;

    localparam logic [7:0] ChDash  = 8'h2D;
    localparam logic [7:0] ChColon = 8'h3A;

    typedef struct packed {
        logic       hex_ok;
        logic [3:0] hex;
        logic       ltr_ok;
        logic [4:0] ltr;
        logic       dash;
        logic       colon;
    } t_cls;

    typedef struct packed {
        t_cls [BufDepth-1:0] cls;
        logic [CntW-1:0]     len;
    } t_entry;

    function automatic t_cls classify(input logic [7:0] c);
        t_cls       r;
        logic [7:0] d;
        r = '0;
        d = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.hex_ok = 1'b1;
            d = c - 8'h30;
            r.hex = d[3:0];
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.hex_ok = 1'b1;
            d = c - 8'h37;
            r.hex = d[3:0];
        end
        r.ltr_ok = 1'b1;
        if (c >= 8'h41 && c <= 8'h48) begin
            d = c - 8'h41;
        end else if (c >= 8'h4A && c <= 8'h4E) begin
            d = c - 8'h42;
        end else if (c == 8'h50) begin
            d = c - 8'h43;
        end else if (c >= 8'h52 && c <= 8'h54) begin
            d = c - 8'h44;
        end else if (c >= 8'h56 && c <= 8'h5A) begin
            d = c - 8'h45;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h1A;
        end else begin
            r.ltr_ok = 1'b0;
            d = '0;
        end
        r.ltr   = d[4:0];
        r.dash  = (c == ChDash);
        r.colon = (c == ChColon);
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/ccsd_front.sv */
// Front end: accepts characters, classifies them and builds a string summary.
// Depends on ccsd_pkg.
`default_nettype none

module ccsd_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire  [7:0]          i_char_code,
    input  wire                 i_last_char,
    input  wire                 i_full,
    output logic                o_push,
    output ccsd_pkg::t_entry    o_entry
);
    import ccsd_pkg::*;

    t_cls            r_buf [BufDepth];
    logic [CntW-1:0] r_cnt;
    logic [CntW-1:0] n_cnt;
    t_cls            w_cls;
    logic            w_acc;

    assign o_stall = i_full;
    assign w_acc   = i_valid && !i_full;
    assign o_push  = w_acc && i_last_char;
    assign w_cls   = classify(i_char_code);

    always_comb begin
        for (int i = 0; i < BufDepth; i++) begin
            o_entry.cls[i] = (r_cnt == CntW'(i)) ? w_cls : r_buf[i];
        end
        o_entry.len = (r_cnt < CntW'(CountMax)) ? r_cnt + 1'b1 : r_cnt;
    end

    always_comb begin
        n_cnt = r_cnt;
        if (w_acc) begin
            if (i_last_char) begin
                n_cnt = '0;
            end else if (r_cnt < CntW'(CountMax)) begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < BufDepth; i++) begin
            if (w_acc && r_cnt == CntW'(i)) begin
                r_buf[i] <= w_cls;
            end
        end
    end

endmodule

`default_nettype wire

/* src/ccsd_queue.sv */
// Short FIFO of string summaries between front end and decoder.
// Depends on ccsd_pkg.
`default_nettype none

module ccsd_queue #(
    parameter int DEPTH = ccsd_pkg::QueueDepth
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  ccsd_pkg::t_entry    i_entry,
    output logic                o_full,
    output logic                o_valid,
    output ccsd_pkg::t_entry    o_entry,
    input  wire                 i_pop
);
    import ccsd_pkg::*;

    localparam int PtrW = $clog2(DEPTH);
    localparam int FilW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [FilW-1:0] r_fill;
    logic [PtrW-1:0] n_wr;
    logic [PtrW-1:0] n_rd;
    logic [FilW-1:0] n_fill;

    assign o_full  = (r_fill == FilW'(DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_entry = r_mem[r_rd];

    always_comb begin
        n_wr   = r_wr;
        n_rd   = r_rd;
        n_fill = r_fill;
        if (i_push) begin
            n_wr = (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (!i_push && i_pop) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

/* src/ccsd_back.sv */
// Back end: matches a string summary against the four code formats, registered result.
// Depends on ccsd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ccsd_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  ccsd_pkg::t_entry    i_entry,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_stall,
    output logic [2:0]          o_code_type,
    output logic [23:0]         o_patch_address,
    output logic [15:0]         o_patch_value,
    output logic [7:0]          o_compare_byte
);
    import ccsd_pkg::*;

    t_cls [BufDepth-1:0] c;
    logic        w_gg8;
    logic        w_ar16;
    logic        w_ar8;
    logic        w_gg16;
    logic        w_ar_pre;
    logic [7:0]  w_rot_src;
    logic [2:0]  n_type;
    logic [23:0] n_addr;
    logic [15:0] n_val;
    logic [7:0]  n_cmp;

    logic        r_valid;
    logic [2:0]  r_type;
    logic [23:0] r_addr;
    logic [15:0] r_val;
    logic [7:0]  r_cmp;

    assign c = i_entry.cls;

    assign w_gg8 = (i_entry.len >= CntW'(11)) && c[3].dash && c[7].dash
                && c[0].hex_ok && c[1].hex_ok && c[2].hex_ok
                && c[4].hex_ok && c[5].hex_ok && c[6].hex_ok
                && c[8].hex_ok && c[9].hex_ok && c[10].hex_ok;

    assign w_ar_pre = c[6].colon && c[0].hex_ok && c[1].hex_ok && c[2].hex_ok
                   && c[3].hex_ok && c[4].hex_ok && c[5].hex_ok
                   && c[7].hex_ok && c[8].hex_ok;
    assign w_ar16 = (i_entry.len >= CntW'(11)) && w_ar_pre
                 && c[9].hex_ok && c[10].hex_ok;
    assign w_ar8  = (i_entry.len >= CntW'(9)) && w_ar_pre;

    assign w_gg16 = (i_entry.len >= CntW'(9)) && c[4].dash
                 && c[0].ltr_ok && c[1].ltr_ok && c[2].ltr_ok && c[3].ltr_ok
                 && c[5].ltr_ok && c[6].ltr_ok && c[7].ltr_ok && c[8].ltr_ok;

    assign w_rot_src = {c[8].hex, c[10].hex};

    always_comb begin
        n_type = CT_NONE;
        n_addr = '0;
        n_val  = '0;
        n_cmp  = '0;
        priority if (w_gg8) begin
            n_type = CT_GG8;
            n_val  = {8'h00, c[0].hex, c[1].hex};
            n_addr = {8'h00, c[6].hex ^ NibbleMask, c[2].hex, c[4].hex, c[5].hex};
            n_cmp  = {w_rot_src[1:0], w_rot_src[7:2]} ^ CmpKey;
        end else if (w_ar16) begin
            n_type = CT_AR16;
            n_addr = {c[0].hex, c[1].hex, c[2].hex, c[3].hex, c[4].hex, c[5].hex};
            n_val  = {c[7].hex, c[8].hex, c[9].hex, c[10].hex};
        end else if (w_ar8) begin
            n_type = CT_AR8;
            n_addr = {c[0].hex, c[1].hex, c[2].hex, c[3].hex, c[4].hex, c[5].hex};
            n_val  = {8'h00, c[7].hex, c[8].hex};
        end else if (w_gg16) begin
            n_type = CT_GG16;
            n_addr = {c[3].ltr[3:0], c[5].ltr[4:1], c[1].ltr[1:0], c[2].ltr,
                      c[3].ltr[4], c[7].ltr[2:0], c[8].ltr};
            n_val  = {c[6].ltr[0], c[7].ltr[4:3], c[5].ltr[0], c[6].ltr[4:1],
                      c[0].ltr, c[1].ltr[4:2]};
        end else begin
            n_type = CT_NONE;
        end
    end

    assign o_pop = i_valid && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_type <= n_type;
            r_addr <= n_addr;
            r_val  <= n_val;
            r_cmp  <= n_cmp;
        end
    end

    assign o_valid         = r_valid;
    assign o_code_type     = r_type;
    assign o_patch_address = r_addr;
    assign o_patch_value   = r_val;
    assign o_compare_byte  = r_cmp;

    `CCSD_ASSERT_IMPL(a_none_zero, i_clk, i_rst_n, r_valid && r_type == CT_NONE, r_addr == '0 && r_val == '0 && r_cmp == '0)
    `CCSD_ASSERT_IMPL(a_cmp_gg8, i_clk, i_rst_n, r_valid && r_cmp != '0, r_type == CT_GG8)
    `CCSD_ASSERT_IMPL(a_byte_val, i_clk, i_rst_n, r_valid && (r_type == CT_GG8 || r_type == CT_AR8), r_val[15:8] == '0)
    `CCSD_ASSERT_NEXT(a_pop_loads, i_clk, i_rst_n, o_pop, r_valid)

endmodule

`default_nettype wire

/* src/cheat_code_string_decoder.sv */
// Cheat code string decoder: one character per cycle in, one decoded code per string out.
// The final character's summary is written into the queue, then into the output register.
// Throughput: one character per cycle unless stalled; back-to-back strings of any length.
// A two-entry summary queue absorbs output stalls before the input is stalled.
// Reset clears the length count, queue pointers and output valid; the buffer is not cleared.
`default_nettype none

module cheat_code_string_decoder #(
    parameter int QUEUE_DEPTH = ccsd_pkg::QueueDepth
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [7:0]  i_char_code,
    input  wire         i_last_char,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [2:0]  o_code_type,
    output logic [23:0] o_patch_address,
    output logic [15:0] o_patch_value,
    output logic [7:0]  o_compare_byte
);
    import ccsd_pkg::*;

    logic   w_push;
    logic   w_full;
    logic   w_q_valid;
    logic   w_pop;
    t_entry w_in_entry;
    t_entry w_q_entry;

    ccsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_entry     (w_in_entry)
    );

    ccsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_in_entry),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry),
        .i_pop   (w_pop)
    );

    ccsd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_q_valid),
        .i_entry         (w_q_entry),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_code_type     (o_code_type),
        .o_patch_address (o_patch_address),
        .o_patch_value   (o_patch_value),
        .o_compare_byte  (o_compare_byte)
    );

endmodule

`default_nettype wire

/* bench/ccsd_checker.sv */
// Checker for the cheat code string decoder: watches both channels, decodes each string
// itself and compares every decoded code field by field. Depends on ccsd_pkg.
`timescale 1ns / 1ps

module ccsd_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_char_valid,
    input  wire         i_char_stall,
    input  wire  [7:0]  i_char_code,
    input  wire         i_last_char,
    input  wire         i_code_valid,
    input  wire         i_code_stall,
    input  wire  [2:0]  i_code_type,
    input  wire  [23:0] i_patch_address,
    input  wire  [15:0] i_patch_value,
    input  wire  [7:0]  i_compare_byte,
    output int          o_mismatches,
    output int          o_pending
);
    import ccsd_pkg::*;

    typedef struct packed {
        logic [2:0]  code_type;
        logic [23:0] addr;
        logic [15:0] value;
        logic [7:0]  cmp;
    } t_patch;

    logic [7:0] kept_chars [BufDepth];
    logic [3:0] char_total = '0;
    t_patch     pending_codes [$];
    t_patch     want;
    int         fault_count = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
        v = c[3:0];
        if (c >= "0" && c <= "9") return 1'b1;
        v = c[3:0] + 4'd9;
        return c >= "A" && c <= "F";
    endfunction

    function automatic bit alpha_index(input logic [7:0] c, output logic [4:0] v);
        string alpha;
        alpha = "ABCDEFGHJKLMNPRSTVWXYZ0123456789";
        v = '0;
        for (int k = 0; k < 32; k++) begin
            if (alpha[k] == c) begin
                v = k[4:0];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit hex_span(input int lo, input int hi, output logic [23:0] acc);
        logic [3:0] v;
        acc = '0;
        for (int k = lo; k <= hi; k++) begin
            if (!hex_digit(kept_chars[k], v)) return 1'b0;
            acc = {acc[19:0], v};
        end
        return 1'b1;
    endfunction

    function automatic t_patch decode_string();
        t_patch      r;
        logic [23:0] a, b, c;
        logic [7:0]  rot;
        logic [4:0]  g [8];
        bit          gg16_ok;
        r = '0;
        gg16_ok = char_total >= 9 && kept_chars[4] == ChDash;
        for (int k = 0; k < 8; k++) begin
            if (!alpha_index(kept_chars[k < 4 ? k : k + 1], g[k])) gg16_ok = 1'b0;
        end
        if (char_total >= 11 && kept_chars[3] == ChDash && kept_chars[7] == ChDash
                && hex_span(0, 2, a) && hex_span(4, 6, b) && hex_span(8, 10, c)) begin
            r.code_type = CT_GG8;
            r.value     = {8'h00, a[11:4]};
            r.addr      = {8'h00, b[3:0] ^ NibbleMask, a[3:0], b[11:4]};
            rot         = {c[11:8], c[3:0]};
            r.cmp       = {rot[1:0], rot[7:2]} ^ CmpKey;
        end else if (char_total >= 11 && kept_chars[6] == ChColon
                && hex_span(0, 5, a) && hex_span(7, 10, b)) begin
            r.code_type = CT_AR16;
            r.addr      = a;
            r.value     = b[15:0];
        end else if (char_total >= 9 && kept_chars[6] == ChColon
                && hex_span(0, 5, a) && hex_span(7, 8, b)) begin
            r.code_type = CT_AR8;
            r.addr      = a;
            r.value     = {8'h00, b[7:0]};
        end else if (gg16_ok) begin
            r.code_type = CT_GG16;
            r.value     = {g[5][0], g[6][4:3], g[4][0], g[5][4:1], g[0], g[1][4:2]};
            r.addr      = {g[3][3:0], g[4][4:1], g[1][1:0], g[2], g[3][4], g[6][2:0], g[7]};
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [23:0] exp_val,
                               input logic [23:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            fault_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            char_total = '0;
        end else begin
            if (i_code_valid && !i_code_stall) begin
                if (pending_codes.size() == 0) begin
                    $error("code_type: expected no transaction, actual 0x%0h", i_code_type);
                    fault_count++;
                end else begin
                    want = pending_codes.pop_front();
                    check_field("code_type", 24'(want.code_type), 24'(i_code_type));
                    check_field("patch_address", want.addr, i_patch_address);
                    check_field("patch_value", 24'(want.value), 24'(i_patch_value));
                    check_field("compare_byte", 24'(want.cmp), 24'(i_compare_byte));
                end
            end
            if (i_char_valid && !i_char_stall) begin
                if (char_total < BufDepth) kept_chars[char_total] = i_char_code;
                if (char_total < CountMax) char_total = char_total + 1'b1;
                if (i_last_char) begin
                    pending_codes.push_back(decode_string());
                    char_total = '0;
                end
            end
        end
        o_pending    <= pending_codes.size();
        o_mismatches <= fault_count;
    end

endmodule

/* bench/testbench.sv */
// Top of the cheat code string decoder bench: clock, reset, string stimulus, output stalls.
// Depends on ccsd_pkg, cheat_code_string_decoder and ccsd_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int QuietLimit  = 2000;
    localparam int HoldCycles  = 250;
    localparam int DrainCycles = 20;
    localparam int PhaseChars  = 150;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        char_valid    = 1'b0;
    logic [7:0]  char_code     = 8'h00;
    logic        last_char     = 1'b0;
    logic        code_stall    = 1'b0;
    logic        char_stall;
    logic        code_valid;
    logic [2:0]  code_type;
    logic [23:0] patch_address;
    logic [15:0] patch_value;
    logic [7:0]  compare_byte;

    int   mismatches;
    int   pending;
    int   idle_pct      = 0;
    int   stall_pct     = 0;
    int   sent_chars    = 0;
    int   quiet_cycles  = 0;
    int   hold_left     = 0;
    logic pressure_req  = 1'b0;
    logic pressure_done = 1'b0;

    always #2 clk = ~clk;

    cheat_code_string_decoder i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (char_valid),
        .o_stall         (char_stall),
        .i_char_code     (char_code),
        .i_last_char     (last_char),
        .o_valid         (code_valid),
        .i_stall         (code_stall),
        .o_code_type     (code_type),
        .o_patch_address (patch_address),
        .o_patch_value   (patch_value),
        .o_compare_byte  (compare_byte)
    );

    ccsd_checker decode_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_char_valid    (char_valid),
        .i_char_stall    (char_stall),
        .i_char_code     (char_code),
        .i_last_char     (last_char),
        .i_code_valid    (code_valid),
        .i_code_stall    (code_stall),
        .i_code_type     (code_type),
        .i_patch_address (patch_address),
        .i_patch_value   (patch_value),
        .i_compare_byte  (compare_byte),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    // output stalls; one long hold-off to back the decoder up
    always @(posedge clk) begin
        if (pressure_req && !pressure_done) begin
            pressure_done <= 1'b1;
            hold_left     <= HoldCycles;
            code_stall    <= 1'b1;
        end else if (hold_left > 1) begin
            hold_left  <= hold_left - 1;
            code_stall <= 1'b1;
        end else begin
            hold_left  <= 0;
            code_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (char_valid && !char_stall) || (code_valid && !code_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QuietLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_char(input logic [7:0] c, input logic fin);
        while ($urandom_range(99) < idle_pct) begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_code  <= c;
        last_char  <= fin;
        @(posedge clk);
        while (char_stall) @(posedge clk);
        sent_chars++;
    endtask

    task automatic send_text(input string s, input int zero_at);
        logic [7:0] c;
        for (int k = 0; k < s.len(); k++) begin
            c = (k == zero_at) ? 8'h00 : s[k];
            send_char(c, k == s.len() - 1);
        end
    endtask

    task automatic send_random_string();
        logic [7:0] text [$];
        int         kind;
        int         len;
        string      hex_set;
        string      ltr_set;
        string      mix_set;
        hex_set = "0123456789ABCDEF";
        ltr_set = "ABCDEFGHJKLMNPRSTVWXYZ0123456789";
        mix_set = "0123456789ABCDEFGHJKLMNPRSTVWXYZIOQUafz-:";
        kind = $urandom_range(9);
        case (kind)
            0, 1: for (int k = 0; k < 11; k++)
                text.push_back((k == 3 || k == 7) ? "-" : hex_set[$urandom_range(15)]);
            2, 3: for (int k = 0; k < 11; k++)
                text.push_back((k == 6) ? ":" : hex_set[$urandom_range(15)]);
            4, 5: for (int k = 0; k < 9; k++)
                text.push_back((k == 6) ? ":" : hex_set[$urandom_range(15)]);
            6, 7: for (int k = 0; k < 9; k++)
                text.push_back((k == 4) ? "-" : ltr_set[$urandom_range(31)]);
            default: begin
                len = (kind == 8) ? $urandom_range(14, 1) : $urandom_range(3, 1);
                for (int k = 0; k < len; k++)
                    text.push_back($urandom_range(1) ? 8'($urandom_range(255))
                                                     : mix_set[$urandom_range(40)]);
            end
        endcase
        if (kind < 8) begin
            if ($urandom_range(4) == 0)
                text[$urandom_range(text.size() - 1)] =
                    $urandom_range(1) ? 8'($urandom_range(255)) : mix_set[$urandom_range(40)];
            if ($urandom_range(7) == 0) begin
                len = $urandom_range(4, 1);
                for (int k = 0; k < len; k++) text.push_back(hex_set[$urandom_range(15)]);
            end else if ($urandom_range(7) == 0) begin
                len = $urandom_range(2, 1);
                for (int k = 0; k < len; k++) void'(text.pop_back());
            end
        end
        for (int k = 0; k < text.size(); k++) send_char(text[k], k == text.size() - 1);
    endtask

    initial begin
        int phase_base;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("FFF-FFF-FFF", -1);
        send_text("000-000-000", -1);
        send_text("A5C-3E7-9B1", -1);
        send_text("FFFFFF:FFFF", -1);
        send_text("000000:00", -1);
        send_text("123456:78G", -1);
        send_text("123456:78GH", -1);
        send_text("ABCDEF:12345678", -1);
        send_text("9999-9999", -1);
        send_text("AAAA-AAAA", -1);
        send_text("SLTV-0ZQ9", -1);
        send_text("abcdef:12", -1);
        send_text("012-345-6Z8", -1);
        send_text("AB0D-EFGH", 2);
        send_text("0", 0);
        send_text("X", -1);
        send_char(8'hFF, 1'b1);

        phase_base = sent_chars;
        for (int p = 0; p < 4; p++) begin
            idle_pct  = (p == 1) ? 61 : (p == 3) ? 30 : 0;
            stall_pct <= (p == 2) ? 61 : (p == 3) ? 30 : 0;
            if (p == 0) pressure_req <= 1'b1;
            while (sent_chars < phase_base + (p + 1) * PhaseChars) send_random_string();
        end
        char_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
